// ===== rtl/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants for the huffman code builder: field widths and defaults.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int MAX_SYMBOLS_DEF = 32;
	localparam int FREQ_WIDTH_DEF  = 24;

	localparam int FREQ_IN_W = 24;
	localparam int SYM_W     = 5;
	localparam int LEN_W     = 5;
	localparam int CODE_W    = 31;

endpackage

// ===== rtl/huffman_code_builder_core.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Loads symbol frequencies, builds a Huffman tree with an array min-heap and
// emits one code per symbol in symbol order.
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid/in_stall) takes one frequency per cycle, symbol 0
//   first; a transfer with last_symbol set closes the alphabet
// - frequencies beyond MAX_SYMBOLS are dropped, a last mark still counts
// - after the last transfer in_stall stays high while the tree is built and
//   every code is emitted
// - build: bottom-up heapify, then n-1 merges; every heap step goes through
//   the heap memory's read and write port; a sift-down level passes
//   S_SD_L, S_SD_LC and S_SD_RC, a sift-up level S_UP and S_UP_CMP
// - emission: each code is walked from leaf to root, one bit per walk step,
//   then each result waits in the output register until out_stall is low
// - one result transfer per symbol; last_code marks the final one, after
//   which the block returns to loading a new alphabet
// - reset empties the alphabet; the heap and tree memories are not cleared,
//   every entry is written before it is read
// ----------------------------------------------------------------------------
module huffman_code_builder_core
	import hcb_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int FREQ_WIDTH  = FREQ_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FREQ_IN_W-1:0] frequency,
	input  logic                 last_symbol,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SYM_W-1:0]     symbol,
	output logic [LEN_W-1:0]     code_length,
	output logic [CODE_W-1:0]    code_bits,
	output logic                 last_code
);

	localparam int IW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int NODES = 2 * MAX_SYMBOLS - 1;
	localparam int NW    = $clog2(NODES);
	localparam int WW    = FREQ_WIDTH + IW;
	localparam int EW    = WW + NW;
	localparam int XW    = IW + 2;
	localparam int MW    = (WW > FREQ_IN_W) ? WW : FREQ_IN_W;
	localparam logic [63:0] FMASK = (64'd1 << FREQ_WIDTH) - 64'd1;

	typedef enum logic [4:0] {
		S_LOAD, S_BLD_RD, S_BLD_CUR, S_SD_L, S_SD_LC, S_SD_RC,
		S_TK_RD0, S_TK_GOT0, S_TK_LAST, S_LINK_A, S_LINK_B,
		S_UP, S_UP_CMP, S_WALK_RD, S_WALK_STEP, S_OUT
	} state_t;

	typedef enum logic [1:0] {P_BUILD, P_TAKE_A, P_TAKE_B} phase_t;

	state_t state_q;
	phase_t ph_q;

	logic [EW-1:0] heap_mem [MAX_SYMBOLS];
	logic [NW:0]   tree_mem [NODES];

	logic [EW-1:0] rd_q;
	logic [NW:0]   tr_q;

	logic [CW-1:0] loaded_q, n_q, cnt_q, s_q;
	logic [IW-1:0] ix_q, bi_q;
	logic [EW-1:0] cur_q, best_q, ea_q, eb_q;
	logic [XW-1:0] bix_q;
	logic          took_q;
	logic [NW-1:0] k_q, root_q, node_q;
	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] bits_q;

	// heap memory write and read ports
	logic          hwe;
	logic [IW-1:0] hwa, hra;
	logic [EW-1:0] hwd;

	logic [XW-1:0] lc, rc;
	logic [IW-1:0] pidx;
	logic [MW-1:0] fext;
	logic [WW-1:0] fmask_w;
	logic [CW-1:0] newn;
	logic          load_ok;
	logic [NW-1:0] merged;
	logic          r_win;
	logic [EW-1:0] chosen;

	assign lc      = {1'b0, ix_q, 1'b1};
	assign rc      = lc + XW'(1);
	assign pidx    = IW'((ix_q - IW'(1)) >> 1);
	assign fext    = MW'(frequency);
	assign fmask_w = WW'(fext) & WW'(FMASK);
	assign load_ok = (loaded_q < CW'(MAX_SYMBOLS));
	assign newn    = load_ok ? loaded_q + CW'(1) : loaded_q;
	assign merged  = NW'(n_q) + k_q;
	assign r_win   = (rc < XW'(cnt_q)) && (rd_q[EW-1:NW] < best_q[EW-1:NW]);
	assign chosen  = r_win ? rd_q : best_q;

	always_comb begin
		hwe = 1'b0;
		hwa = ix_q;
		hwd = cur_q;
		hra = ix_q;
		unique case (state_q)
			S_LOAD: begin
				hwe = in_valid && load_ok;
				hwa = IW'(loaded_q);
				hwd = {fmask_w, NW'(loaded_q)};
			end
			S_BLD_RD: hra = bi_q;
			S_SD_L: begin
				hra = IW'(lc);
				hwe = !(lc < XW'(cnt_q));
			end
			S_SD_LC: hra = IW'(rc);
			S_SD_RC: begin
				hwe = 1'b1;
				hwd = (r_win || took_q) ? chosen : cur_q;
			end
			S_TK_RD0: hra = '0;
			S_TK_GOT0: hra = IW'(cnt_q - CW'(1));
			S_UP: begin
				hra = pidx;
				hwe = (ix_q == '0);
			end
			S_UP_CMP: begin
				hwe = 1'b1;
				hwd = (rd_q[EW-1:NW] > cur_q[EW-1:NW]) ? rd_q : cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hwe)
			heap_mem[hwa] <= hwd;
		rd_q <= heap_mem[hra];
		if (state_q == S_LINK_A)
			tree_mem[ea_q[NW-1:0]] <= {1'b0, merged};
		if (state_q == S_LINK_B)
			tree_mem[eb_q[NW-1:0]] <= {1'b1, merged};
		tr_q <= tree_mem[node_q];
	end

	assign in_stall    = (state_q != S_LOAD);
	assign out_valid   = (state_q == S_OUT);
	assign symbol      = SYM_W'(s_q);
	assign code_length = len_q;
	assign code_bits   = bits_q;
	assign last_code   = (s_q + CW'(1) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			ph_q     <= P_BUILD;
			loaded_q <= '0;
			cnt_q    <= '0;
			n_q      <= '0;
			s_q      <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (last_symbol) begin
							loaded_q <= '0;
							n_q      <= newn;
							cnt_q    <= newn;
							root_q   <= '0;
							k_q      <= '0;
							s_q      <= '0;
							node_q   <= '0;
							len_q    <= '0;
							bits_q   <= '0;
							bi_q     <= IW'(newn >> 1);
							ph_q     <= P_BUILD;
							state_q  <= (newn > CW'(1)) ? S_BLD_RD : S_WALK_RD;
						end else begin
							loaded_q <= newn;
						end
					end
				end
				S_BLD_RD: state_q <= S_BLD_CUR;
				S_BLD_CUR: begin
					cur_q   <= rd_q;
					ix_q    <= bi_q;
					state_q <= S_SD_L;
				end
				S_SD_L: begin
					if (lc < XW'(cnt_q)) begin
						state_q <= S_SD_LC;
					end else begin
						// sift-down finished, hole filled with the moving entry
						unique case (ph_q)
							P_BUILD: begin
								if (bi_q == '0) begin
									ph_q    <= P_TAKE_A;
									state_q <= S_TK_RD0;
								end else begin
									bi_q    <= bi_q - IW'(1);
									state_q <= S_BLD_RD;
								end
							end
							P_TAKE_A: begin
								ph_q    <= P_TAKE_B;
								state_q <= S_TK_RD0;
							end
							default: state_q <= S_LINK_A;
						endcase
					end
				end
				S_SD_LC: begin
					if (rd_q[EW-1:NW] < cur_q[EW-1:NW]) begin
						best_q <= rd_q;
						took_q <= 1'b1;
					end else begin
						best_q <= cur_q;
						took_q <= 1'b0;
					end
					bix_q   <= lc;
					state_q <= S_SD_RC;
				end
				S_SD_RC: begin
					if (r_win || took_q) begin
						ix_q    <= IW'(r_win ? rc : bix_q);
						state_q <= S_SD_L;
					end else begin
						// cur already written back this cycle; reuse done path
						unique case (ph_q)
							P_BUILD: begin
								if (bi_q == '0) begin
									ph_q    <= P_TAKE_A;
									state_q <= S_TK_RD0;
								end else begin
									bi_q    <= bi_q - IW'(1);
									state_q <= S_BLD_RD;
								end
							end
							P_TAKE_A: begin
								ph_q    <= P_TAKE_B;
								state_q <= S_TK_RD0;
							end
							default: state_q <= S_LINK_A;
						endcase
					end
				end
				S_TK_RD0: state_q <= S_TK_GOT0;
				S_TK_GOT0: begin
					if (ph_q == P_TAKE_A)
						ea_q <= rd_q;
					else
						eb_q <= rd_q;
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_TK_LAST;
				end
				S_TK_LAST: begin
					cur_q   <= rd_q;
					ix_q    <= '0;
					state_q <= S_SD_L;
				end
				S_LINK_A: state_q <= S_LINK_B;
				S_LINK_B: begin
					cur_q   <= {ea_q[EW-1:NW] + eb_q[EW-1:NW], merged};
					ix_q    <= IW'(cnt_q);
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_UP;
				end
				S_UP: begin
					if (ix_q == '0) begin
						root_q <= merged;
						k_q    <= k_q + NW'(1);
						if (CW'(k_q) + CW'(2) < n_q) begin
							ph_q    <= P_TAKE_A;
							state_q <= S_TK_RD0;
						end else begin
							state_q <= S_WALK_RD;
						end
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (rd_q[EW-1:NW] > cur_q[EW-1:NW]) begin
						ix_q    <= pidx;
						state_q <= S_UP;
					end else begin
						root_q <= merged;
						k_q    <= k_q + NW'(1);
						if (CW'(k_q) + CW'(2) < n_q) begin
							ph_q    <= P_TAKE_A;
							state_q <= S_TK_RD0;
						end else begin
							state_q <= S_WALK_RD;
						end
					end
				end
				S_WALK_RD: state_q <= (node_q == root_q) ? S_OUT : S_WALK_STEP;
				S_WALK_STEP: begin
					bits_q[len_q] <= tr_q[NW];
					len_q   <= len_q + LEN_W'(1);
					node_q  <= tr_q[NW-1:0];
					state_q <= S_WALK_RD;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (s_q + CW'(1) == n_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							s_q     <= s_q + CW'(1);
							node_q  <= NW'(s_q + CW'(1));
							len_q   <= '0;
							bits_q  <= '0;
							state_q <= S_WALK_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input taken while a result is pending");

	// results only cover loaded symbols
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (s_q < n_q) && (cnt_q <= CW'(MAX_SYMBOLS)))
		else $error("result symbol out of range");

	// after the final code transfer the block loads again
	a_return: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_code |=> !in_stall && !out_valid)
		else $error("block did not return to loading");

endmodule

// ===== sim/huffman_code_builder_core_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_core_tb
// Sends alphabets of symbol frequencies into the code builder and checks each
// emitted code against a heap-exact Huffman predictor, under varied idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_builder_core_tb;
	import hcb_pkg::*;

	localparam int NSYM  = MAX_SYMBOLS_DEF;
	localparam int NNODE = 2 * NSYM - 1;

	typedef struct {
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
		logic              last;
	} code_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [FREQ_IN_W-1:0] frequency;
	logic                 last_symbol;
	logic                 out_valid;
	logic                 out_stall;
	logic [SYM_W-1:0]     symbol;
	logic [LEN_W-1:0]     code_length;
	logic [CODE_W-1:0]    code_bits;
	logic                 last_code;

	// predictor state
	longint unsigned heap_w[NSYM];
	int              heap_id[NSYM];
	int              parent_of[NNODE];
	bit              side_of[NNODE];
	int              n_loaded;
	int              heap_size;
	code_t           pending_codes[$];

	int errors;
	int items_sent;
	int codes_seen;
	int alphabets;
	int idle_pct;
	int stall_pct;
	int hold_cycles;

	huffman_code_builder_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.frequency(frequency), .last_symbol(last_symbol),
		.out_valid(out_valid), .out_stall(out_stall),
		.symbol(symbol), .code_length(code_length),
		.code_bits(code_bits), .last_code(last_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("huffman_code_builder_core: mismatch");
		$finish;
	end

	function automatic void swap_heap(int a, int b);
		longint unsigned w;
		int id;
		w = heap_w[a]; id = heap_id[a];
		heap_w[a] = heap_w[b]; heap_id[a] = heap_id[b];
		heap_w[b] = w; heap_id[b] = id;
	endfunction

	function automatic void heap_sink(int start, int cnt);
		int i, l, r, s;
		i = start;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			s = i;
			if (l < cnt && heap_w[l] < heap_w[i]) s = l;
			if (r < cnt && heap_w[r] < heap_w[s]) s = r;
			if (s == i) break;
			swap_heap(s, i);
			i = s;
		end
	endfunction

	function automatic void heap_pop(output longint unsigned w, output int id);
		w = heap_w[0];
		id = heap_id[0];
		heap_size--;
		heap_w[0] = heap_w[heap_size];
		heap_id[0] = heap_id[heap_size];
		heap_sink(0, heap_size);
	endfunction

	function automatic void heap_push(longint unsigned w, int id);
		int idx, par;
		idx = heap_size;
		heap_w[idx] = w;
		heap_id[idx] = id;
		heap_size++;
		while (idx > 0) begin
			par = (idx - 1) / 2;
			if (heap_w[par] > heap_w[idx]) begin
				swap_heap(par, idx);
				idx = par;
			end else break;
		end
	endfunction

	// builds the tree for the loaded alphabet and queues one code per symbol
	function automatic void build_codes();
		int n, root, node, len;
		longint unsigned wa, wb, bits;
		int na, nb;
		code_t c;
		n = n_loaded;
		heap_size = n;
		root = 0;
		if (n > 1) begin
			for (int i = n / 2; i >= 0; i--) heap_sink(i, n);
			for (int k = 0; k + 1 < n; k++) begin
				heap_pop(wa, na);
				heap_pop(wb, nb);
				parent_of[na] = n + k; side_of[na] = 1'b0;
				parent_of[nb] = n + k; side_of[nb] = 1'b1;
				heap_push(wa + wb, n + k);
				root = n + k;
			end
		end
		for (int s = 0; s < n; s++) begin
			bits = 0;
			len = 0;
			node = s;
			if (n > 1)
				while (node != root && len < NSYM && node < NNODE) begin
					bits |= longint'(side_of[node]) << len;
					len++;
					node = parent_of[node];
				end
			c.sym = s[SYM_W-1:0];
			c.len = len[LEN_W-1:0];
			c.bits = bits[CODE_W-1:0];
			c.last = (s + 1 == n);
			pending_codes.push_back(c);
		end
		n_loaded = 0;
		heap_size = 0;
		alphabets++;
	endfunction

	function automatic void load_symbol(logic [FREQ_IN_W-1:0] f, logic l);
		if (n_loaded < NSYM) begin
			heap_w[n_loaded] = longint'(f);
			heap_id[n_loaded] = n_loaded;
			n_loaded++;
		end
		if (l) build_codes();
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// result side: stall pattern and long hold-off
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		code_t e;
		if (arst_n && out_valid && !out_stall) begin
			codes_seen++;
			if (pending_codes.size() == 0)
				report("unexpected code transfer, symbol", symbol, -1);
			else begin
				e = pending_codes.pop_front();
				if (symbol !== e.sym) report("symbol", symbol, e.sym);
				if (code_length !== e.len) report("code_length", code_length, e.len);
				if (code_bits !== e.bits) report("code_bits", code_bits, e.bits);
				if (last_code !== e.last) report("last_code", last_code, e.last);
			end
		end
	end

	task automatic send_symbol(logic [FREQ_IN_W-1:0] f, logic l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		frequency <= f;
		last_symbol <= l;
		do @(posedge clk); while (in_stall);
		load_symbol(f, l);
		items_sent++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		go_quiet();
		wait (pending_codes.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [FREQ_IN_W-1:0] pick_freq(int mode);
		case (mode)
			0: return FREQ_IN_W'($urandom_range(3));
			1: return FREQ_IN_W'($urandom_range(255));
			2: return {FREQ_IN_W{1'b1}} - FREQ_IN_W'($urandom_range(2));
			default: return FREQ_IN_W'($urandom);
		endcase
	endfunction

	task automatic send_alphabet(int n, int mode);
		for (int i = 0; i < n; i++) send_symbol(pick_freq(mode), i == n - 1);
	endtask

	task automatic test_directed();
		int fa, fb, ft;
		idle_pct = 0; stall_pct = 0;
		send_symbol({FREQ_IN_W{1'b1}}, 1'b1);
		send_symbol('0, 1'b0); send_symbol('0, 1'b1);
		for (int i = 0; i < 3; i++) send_symbol(24'd7, i == 2);
		for (int i = 0; i < 4; i++) send_symbol({FREQ_IN_W{1'b1}}, i == 3);
		// fibonacci weights give the deepest tree
		fa = 1; fb = 1;
		for (int i = 0; i < 12; i++) begin
			send_symbol(FREQ_IN_W'(fa), i == 11);
			ft = fa + fb; fa = fb; fb = ft;
		end
		drain();
	endtask

	task automatic test_full_alphabet();
		idle_pct = 10; stall_pct = 10;
		// extra symbols beyond the limit are dropped, last mark still closes
		for (int i = 0; i < NSYM + 3; i++) send_symbol(pick_freq(3), i == NSYM + 2);
		// deep tree with all 32 symbols
		for (int i = 0; i < NSYM; i++)
			send_symbol(FREQ_IN_W'(i < 2 ? 1 : (1 << (i - 1 > 23 ? 23 : i - 1))),
				i == NSYM - 1);
		drain();
	endtask

	task automatic test_random(int n_items, int ip, int sp);
		int goal;
		idle_pct = ip; stall_pct = sp;
		goal = items_sent + n_items;
		while (items_sent < goal)
			send_alphabet($urandom_range(9) == 0 ? $urandom_range(17, 32) :
				$urandom_range(1, 12), $urandom_range(3));
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0; stall_pct = 20;
		hold_cycles = 1500;
		send_alphabet(20, 3);
		send_alphabet(6, 0);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		frequency = '0;
		last_symbol = 1'b0;
		errors = 0; items_sent = 0; codes_seen = 0; alphabets = 0;
		n_loaded = 0; heap_size = 0;
		idle_pct = 0; stall_pct = 0; hold_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_alphabet();
		test_random(60, 0, 0);
		test_random(60, 80, 0);
		test_random(60, 0, 80);
		test_random(50, 29, 29);
		test_backpressure();

		$display("sent %0d frequencies in %0d alphabets, checked %0d codes",
			items_sent, alphabets, codes_seen);
		$display("covered ties, saturated weights, deep trees, overflow and long stalls");
		if (errors == 0 && pending_codes.size() == 0)
			$display("huffman_code_builder_core: match");
		else
			$display("huffman_code_builder_core: mismatch");
		$finish;
	end

endmodule

// ===== huffman_code_builder_core.f =====
rtl/hcb_pkg.sv
rtl/huffman_code_builder_core.sv
sim/huffman_code_builder_core_tb.sv
